### src/mpbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared constants and codes of the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
package mpbm_pkg;

    localparam int DEF_MAX_STATES = 1024;
    localparam int DEF_ID_BITS    = 16;
    localparam int ALPHABET       = 256;
    localparam int BYTE_BITS      = 8;
    localparam int TAG_BITS       = 16;
    localparam int ACT_BITS       = 2;
    localparam int STATUS_BITS    = 2;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_ADD     = 2'd0,
        ACT_COMPILE = 2'd1,
        ACT_SCAN    = 2'd2,
        ACT_REWIND  = 2'd3
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_SCAN     = 2'd0,
        ST_COMPILED = 2'd1,
        ST_FULL     = 2'd2,
        ST_LATE_ADD = 2'd3
    } status_t;

endpackage

### src/mpbm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbm_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module mpbm_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/mpbm_node_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbm_node_ram
// Per-state record: failure link, id-present bit and pattern id.
// Link and id fields are written separately at one address.
// ----------------------------------------------------------------------------
module mpbm_node_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int IW    = 16
) (
    input  logic          clk,
    input  logic          fail_we,
    input  logic          id_we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] fail_wdata,
    input  logic          has_wdata,
    input  logic [IW-1:0] id_wdata,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] fail_rd,
    output logic          has_rd,
    output logic [IW-1:0] id_rd
);

    logic [AW-1:0] fail_mem [DEPTH];
    logic          has_mem  [DEPTH];
    logic [IW-1:0] id_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[waddr] <= fail_wdata;
        end
        if (id_we)
        begin
            has_mem[waddr] <= has_wdata;
            id_mem[waddr]  <= id_wdata;
        end
        fail_rd <= fail_mem[raddr];
        has_rd  <= has_mem[raddr];
        id_rd   <= id_mem[raddr];
    end

endmodule

### src/mpbm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbm_ctrl
// Sequencer: clear sweep, trie insert, failure-link build and scan walk.
// ----------------------------------------------------------------------------
module mpbm_ctrl #(
    parameter int MAX_STATES = mpbm_pkg::DEF_MAX_STATES,
    parameter int ID_BITS    = mpbm_pkg::DEF_ID_BITS,
    parameter int SW         = $clog2(MAX_STATES),
    parameter int GW         = SW + mpbm_pkg::BYTE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mpbm_pkg::ACT_BITS-1:0]    action,
    input  logic [mpbm_pkg::BYTE_BITS-1:0]   data_byte,
    input  logic                             pattern_start,
    input  logic                             pattern_end,
    input  logic [mpbm_pkg::TAG_BITS-1:0]    pattern_tag,
    input  logic                             cfg_write,
    input  logic [mpbm_pkg::TAG_BITS-1:0]    cfg_data,
    output logic                             result_valid,
    output logic [mpbm_pkg::TAG_BITS-1:0]    match_id,
    output logic [mpbm_pkg::STATUS_BITS-1:0] status,
    // goto table
    output logic                             goto_we,
    output logic [GW-1:0]                    goto_waddr,
    output logic [SW-1:0]                    goto_wdata,
    output logic [GW-1:0]                    goto_raddr,
    input  logic [SW-1:0]                    goto_rdata,
    // node record
    output logic                             node_fail_we,
    output logic                             node_id_we,
    output logic [SW-1:0]                    node_waddr,
    output logic [SW-1:0]                    node_fail_wdata,
    output logic                             node_has_wdata,
    output logic [ID_BITS-1:0]               node_id_wdata,
    output logic [SW-1:0]                    node_raddr,
    input  logic [SW-1:0]                    node_fail_rd,
    input  logic                             node_has_rd,
    input  logic [ID_BITS-1:0]               node_id_rd,
    // bfs queue
    output logic                             q_we,
    output logic [SW-1:0]                    q_waddr,
    output logic [SW-1:0]                    q_wdata,
    output logic [SW-1:0]                    q_raddr,
    input  logic [SW-1:0]                    q_rdata
);

    import mpbm_pkg::*;

    localparam int GDEPTH = MAX_STATES * ALPHABET;
    localparam logic [SW:0] MAX_CNT = (SW+1)'(MAX_STATES);

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_ADD_EVAL = 15'b000000000000100,
        S_SC_RD    = 15'b000000000001000,
        S_SC_EVAL  = 15'b000000000010000,
        S_SC_ID    = 15'b000000000100000,
        S_CR_RD    = 15'b000000001000000,
        S_CR_EVAL  = 15'b000000010000000,
        S_CQ_RD    = 15'b000000100000000,
        S_CQ_U     = 15'b000001000000000,
        S_CQ_FU    = 15'b000010000000000,
        S_CV_RD    = 15'b000100000000000,
        S_CV_EVAL  = 15'b001000000000000,
        S_CW_RD    = 15'b010000000000000,
        S_CW_EVAL  = 15'b100000000000000
    } state_t;

    // control
    state_t          state_reg, state_next;
    logic [GW-1:0]   clr_reg, clr_next;
    logic [SW-1:0]   ip_reg, ip_next;
    logic            drop_reg, drop_next;
    logic [SW:0]     used_reg, used_next;
    logic            compiled_reg, compiled_next;
    logic [SW-1:0]   match_reg, match_next;
    logic [SW:0]     head_reg, head_next;
    logic [SW:0]     tail_reg, tail_next;
    logic [TAG_BITS-1:0] nm_reg, nm_next;
    logic            valid_reg, valid_next;
    // payload
    logic [BYTE_BITS-1:0] byte_reg, byte_next;
    logic            end_reg, end_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [SW-1:0]   s_reg, s_next;
    logic [SW:0]     hops_reg, hops_next;
    logic [BYTE_BITS-1:0] c_reg, c_next;
    logic [SW-1:0]   u_reg, u_next;
    logic [SW-1:0]   fu_reg, fu_next;
    logic [SW-1:0]   v_reg, v_next;
    logic [TAG_BITS-1:0] oid_reg, oid_next;
    logic [STATUS_BITS-1:0] ost_reg, ost_next;

    action_t act;
    logic    stop;

    assign act  = action_t'(action);
    // failure walk ends at the root, at a state with a child, or at the hop bound
    assign stop = (s_reg == '0) || (goto_rdata != '0) || (hops_reg == MAX_CNT);

    always_comb
    begin
        logic [SW-1:0] ip_eff;
        logic          drop_eff;
        ip_eff          = ip_reg;
        drop_eff        = drop_reg;
        state_next      = state_reg;
        clr_next        = clr_reg;
        ip_next         = ip_reg;
        drop_next       = drop_reg;
        used_next       = used_reg;
        compiled_next   = compiled_reg;
        match_next      = match_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        nm_next         = cfg_write ? cfg_data : nm_reg;
        valid_next      = 1'b0;
        byte_next       = byte_reg;
        end_next        = end_reg;
        tag_next        = tag_reg;
        s_next          = s_reg;
        hops_next       = hops_reg;
        c_next          = c_reg;
        u_next          = u_reg;
        fu_next         = fu_reg;
        v_next          = v_reg;
        oid_next        = oid_reg;
        ost_next        = ost_reg;
        goto_we         = 1'b0;
        goto_waddr      = {ip_reg, byte_reg};
        goto_wdata      = '0;
        goto_raddr      = {s_reg, byte_reg};
        node_fail_we    = 1'b0;
        node_id_we      = 1'b0;
        node_waddr      = '0;
        node_fail_wdata = '0;
        node_has_wdata  = 1'b0;
        node_id_wdata   = '0;
        node_raddr      = s_reg;
        q_we            = 1'b0;
        q_waddr         = tail_reg[SW-1:0];
        q_wdata         = v_reg;
        q_raddr         = head_reg[SW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                goto_we    = 1'b1;
                goto_waddr = clr_reg;
                if (clr_reg < GW'(MAX_STATES))
                begin
                    node_fail_we = 1'b1;
                    node_id_we   = 1'b1;
                    node_waddr   = clr_reg[SW-1:0];
                end
                if (clr_reg == GW'(GDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + GW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    byte_next = data_byte;
                    end_next  = pattern_end;
                    tag_next  = pattern_tag;
                    case (act)
                        ACT_ADD:
                        begin
                            if (compiled_reg)
                            begin
                                valid_next = 1'b1;
                                oid_next   = '0;
                                ost_next   = ST_LATE_ADD;
                            end
                            else
                            begin
                                ip_eff    = pattern_start ? '0 : ip_reg;
                                drop_eff  = pattern_start ? 1'b0 : drop_reg;
                                ip_next   = ip_eff;
                                drop_next = drop_eff;
                                if (drop_eff)
                                begin
                                    valid_next = 1'b1;
                                    oid_next   = '0;
                                    ost_next   = ST_FULL;
                                end
                                else
                                begin
                                    goto_raddr = {ip_eff, data_byte};
                                    state_next = S_ADD_EVAL;
                                end
                            end
                        end
                        ACT_COMPILE:
                        begin
                            node_fail_we = 1'b1;
                            node_waddr   = '0;
                            c_next       = '0;
                            head_next    = '0;
                            tail_next    = '0;
                            state_next   = S_CR_RD;
                        end
                        ACT_SCAN:
                        begin
                            s_next     = match_reg;
                            hops_next  = '0;
                            state_next = S_SC_RD;
                        end
                        ACT_REWIND:
                        begin
                            match_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_EVAL:
            begin
                state_next = S_IDLE;
                if ((goto_rdata == '0) && (used_reg >= MAX_CNT))
                begin
                    drop_next  = 1'b1;
                    valid_next = 1'b1;
                    oid_next   = '0;
                    ost_next   = ST_FULL;
                end
                else
                begin
                    if (goto_rdata == '0)
                    begin
                        goto_we    = 1'b1;
                        goto_wdata = used_reg[SW-1:0];
                        used_next  = used_reg + (SW+1)'(1);
                        ip_next    = used_reg[SW-1:0];
                    end
                    else
                    begin
                        ip_next = goto_rdata;
                    end
                    if (end_reg)
                    begin
                        node_id_we     = 1'b1;
                        node_waddr     = ip_next;
                        node_has_wdata = 1'b1;
                        node_id_wdata  = ID_BITS'(tag_reg);
                    end
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_EVAL;
            end
            S_SC_EVAL:
            begin
                if (stop)
                begin
                    match_next = (goto_rdata != '0) ? goto_rdata : s_reg;
                    node_raddr = match_next;
                    state_next = S_SC_ID;
                end
                else
                begin
                    s_next     = node_fail_rd;
                    hops_next  = hops_reg + (SW+1)'(1);
                    state_next = S_SC_RD;
                end
            end
            S_SC_ID:
            begin
                valid_next = 1'b1;
                oid_next   = node_has_rd ? TAG_BITS'(node_id_rd) : nm_reg;
                ost_next   = ST_SCAN;
                state_next = S_IDLE;
            end
            S_CR_RD:
            begin
                goto_raddr = {SW'(0), c_reg};
                state_next = S_CR_EVAL;
            end
            S_CR_EVAL:
            begin
                if ((goto_rdata != '0) && (tail_reg < MAX_CNT))
                begin
                    node_fail_we = 1'b1;
                    node_waddr   = goto_rdata;
                    q_we         = 1'b1;
                    q_wdata      = goto_rdata;
                    tail_next    = tail_reg + (SW+1)'(1);
                end
                c_next     = c_reg + BYTE_BITS'(1);
                state_next = (c_reg == '1) ? S_CQ_RD : S_CR_RD;
            end
            S_CQ_RD:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + (SW+1)'(1);
                    state_next = S_CQ_U;
                end
                else
                begin
                    compiled_next = 1'b1;
                    valid_next    = 1'b1;
                    oid_next      = '0;
                    ost_next      = ST_COMPILED;
                    state_next    = S_IDLE;
                end
            end
            S_CQ_U:
            begin
                u_next     = q_rdata;
                node_raddr = q_rdata;
                state_next = S_CQ_FU;
            end
            S_CQ_FU:
            begin
                fu_next    = node_fail_rd;
                c_next     = '0;
                state_next = S_CV_RD;
            end
            S_CV_RD:
            begin
                goto_raddr = {u_reg, c_reg};
                state_next = S_CV_EVAL;
            end
            S_CV_EVAL:
            begin
                if (goto_rdata == '0)
                begin
                    c_next     = c_reg + BYTE_BITS'(1);
                    state_next = (c_reg == '1) ? S_CQ_RD : S_CV_RD;
                end
                else
                begin
                    v_next     = goto_rdata;
                    s_next     = fu_reg;
                    hops_next  = '0;
                    state_next = S_CW_RD;
                end
            end
            S_CW_RD:
            begin
                goto_raddr = {s_reg, c_reg};
                state_next = S_CW_EVAL;
            end
            S_CW_EVAL:
            begin
                if (stop)
                begin
                    node_fail_we    = 1'b1;
                    node_waddr      = v_reg;
                    node_fail_wdata = goto_rdata;
                    if (tail_reg < MAX_CNT)
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + (SW+1)'(1);
                    end
                    c_next     = c_reg + BYTE_BITS'(1);
                    state_next = (c_reg == '1) ? S_CQ_RD : S_CV_RD;
                end
                else
                begin
                    s_next     = node_fail_rd;
                    hops_next  = hops_reg + (SW+1)'(1);
                    state_next = S_CW_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            ip_reg       <= '0;
            drop_reg     <= 1'b0;
            used_reg     <= (SW+1)'(1);
            compiled_reg <= 1'b0;
            match_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            nm_reg       <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            ip_reg       <= ip_next;
            drop_reg     <= drop_next;
            used_reg     <= used_next;
            compiled_reg <= compiled_next;
            match_reg    <= match_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nm_reg       <= nm_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
        tag_reg  <= tag_next;
        s_reg    <= s_next;
        hops_reg <= hops_next;
        c_reg    <= c_next;
        u_reg    <= u_next;
        fu_reg   <= fu_next;
        v_reg    <= v_next;
        oid_reg  <= oid_next;
        ost_reg  <= ost_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign match_id     = oid_reg;
    assign status       = ost_reg;

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (state_reg == S_IDLE))
        else $error("result beat while sequencer busy");

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg >= (SW+1)'(1)) && (used_reg <= MAX_CNT))
        else $error("state counter out of range");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= tail_reg) && (tail_reg <= MAX_CNT))
        else $error("bfs queue pointers inconsistent");

    a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == S_CLEAR) && (state_reg != S_CLEAR)
        |-> ($past(clr_reg) == GW'(GDEPTH - 1)))
        else $error("clear sweep ended early");

endmodule

### src/multi_pattern_byte_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher
// Aho-Corasick trie builder and byte-stream matcher over on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   Command beat: start high while busy is low accepts action, data_byte,
//   pattern_start, pattern_end and pattern_tag. Results appear for exactly
//   one cycle with result_valid high; the receiver cannot stall them.
//   The user writes no_match_id via cfg_write/cfg_data only while idle; unchecked.
// Sequence from accept until busy drops:
//   add byte: goto read, then insert write; no result unless full/late.
//   late add, add while dropping: result next cycle, no busy time.
//   rewind: no result, no busy time.
//   scan byte: a goto/node read, another per failure hop, then an id read.
//   compile: root row read byte by byte, then per queued state its row byte by
//     byte plus a failure walk per child; one goto read at a time.
// Reset: the goto table (MAX_STATES*256 words) and node records are swept
//   to zero, one word per cycle; busy stays high until the sweep ends.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher #(
    parameter int MAX_STATES = mpbm_pkg::DEF_MAX_STATES,
    parameter int ID_BITS    = mpbm_pkg::DEF_ID_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mpbm_pkg::ACT_BITS-1:0]    action,
    input  logic [mpbm_pkg::BYTE_BITS-1:0]   data_byte,
    input  logic                             pattern_start,
    input  logic                             pattern_end,
    input  logic [mpbm_pkg::TAG_BITS-1:0]    pattern_tag,
    input  logic                             cfg_write,
    input  logic [mpbm_pkg::TAG_BITS-1:0]    cfg_data,
    output logic                             result_valid,
    output logic [mpbm_pkg::TAG_BITS-1:0]    match_id,
    output logic [mpbm_pkg::STATUS_BITS-1:0] status
);

    import mpbm_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int GW = SW + BYTE_BITS;

    // goto table port
    logic          goto_we;
    logic [GW-1:0] goto_waddr, goto_raddr;
    logic [SW-1:0] goto_wdata, goto_rdata;
    // node record port
    logic               node_fail_we, node_id_we, node_has_wdata, node_has_rd;
    logic [SW-1:0]      node_waddr, node_fail_wdata, node_raddr, node_fail_rd;
    logic [ID_BITS-1:0] node_id_wdata, node_id_rd;
    // bfs queue port
    logic          q_we;
    logic [SW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

    mpbm_ctrl #(
        .MAX_STATES (MAX_STATES),
        .ID_BITS    (ID_BITS),
        .SW         (SW),
        .GW         (GW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .data_byte       (data_byte),
        .pattern_start   (pattern_start),
        .pattern_end     (pattern_end),
        .pattern_tag     (pattern_tag),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .match_id        (match_id),
        .status          (status),
        .goto_we         (goto_we),
        .goto_waddr      (goto_waddr),
        .goto_wdata      (goto_wdata),
        .goto_raddr      (goto_raddr),
        .goto_rdata      (goto_rdata),
        .node_fail_we    (node_fail_we),
        .node_id_we      (node_id_we),
        .node_waddr      (node_waddr),
        .node_fail_wdata (node_fail_wdata),
        .node_has_wdata  (node_has_wdata),
        .node_id_wdata   (node_id_wdata),
        .node_raddr      (node_raddr),
        .node_fail_rd    (node_fail_rd),
        .node_has_rd     (node_has_rd),
        .node_id_rd      (node_id_rd),
        .q_we            (q_we),
        .q_waddr         (q_waddr),
        .q_wdata         (q_wdata),
        .q_raddr         (q_raddr),
        .q_rdata         (q_rdata)
    );

    // child index per (state, byte); zero means no child
    mpbm_ram #(
        .DEPTH (MAX_STATES * ALPHABET),
        .AW    (GW),
        .DW    (SW)
    ) u_goto (
        .clk   (clk),
        .we    (goto_we),
        .waddr (goto_waddr),
        .wdata (goto_wdata),
        .raddr (goto_raddr),
        .rdata (goto_rdata)
    );

    // failure link and pattern id per state
    mpbm_node_ram #(
        .DEPTH (MAX_STATES),
        .AW    (SW),
        .IW    (ID_BITS)
    ) u_node (
        .clk        (clk),
        .fail_we    (node_fail_we),
        .id_we      (node_id_we),
        .waddr      (node_waddr),
        .fail_wdata (node_fail_wdata),
        .has_wdata  (node_has_wdata),
        .id_wdata   (node_id_wdata),
        .raddr      (node_raddr),
        .fail_rd    (node_fail_rd),
        .has_rd     (node_has_rd),
        .id_rd      (node_id_rd)
    );

    // breadth-first work list, always written before read
    mpbm_ram #(
        .DEPTH (MAX_STATES),
        .AW    (SW),
        .DW    (SW)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_pattern_byte_matcher. Builds a trie until it
// overflows, compiles it twice and scans streams cut from the stored patterns
// plus noise after each compile, checking each result beat against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
    import mpbm_pkg::*;

    localparam int NSTATES = DEF_MAX_STATES;

    typedef struct {
        action_t         act;
        logic [7:0]      dbyte;
        logic            first;
        logic            last;
        logic [15:0]     tag;
    } cmd_t;

    typedef struct {
        logic [15:0] id;
        status_t     st;
    } resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = '0;
    logic [7:0]  data_byte = '0;
    logic        pattern_start = 1'b0;
    logic        pattern_end = 1'b0;
    logic [15:0] pattern_tag = '0;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        result_valid;
    logic [15:0] match_id;
    logic [1:0]  status;

    multi_pattern_byte_matcher uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .data_byte(data_byte), .pattern_start(pattern_start),
        .pattern_end(pattern_end), .pattern_tag(pattern_tag),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .result_valid(result_valid), .match_id(match_id), .status(status)
    );

    always #2 clk = ~clk;

    // ---------------- shadow matcher state ----------------
    logic [9:0]  child_tbl [NSTATES*256];
    logic [9:0]  fail_ptr  [NSTATES];
    logic [15:0] end_tag   [NSTATES];
    bit          tagged_st [NSTATES];
    logic [9:0]  walk_q    [NSTATES];
    logic [9:0]  scan_at;
    logic [9:0]  ins_at;
    int          nodes_used;
    bit          built;
    bit          dropping;
    logic [15:0] miss_id;

    cmd_t        pending [$];
    resp_t       expected [$];
    logic [7:0]  pat_bytes [$];   // pattern bytes from the add helpers and three directed adds, in order: scan material
    int          errors = 0;
    bit          quiet = 1'b0;
    int          gap = 0;
    cmd_t        cur;

    function automatic logic [9:0] child(logic [9:0] s, logic [7:0] c);
        return child_tbl[{s, c}];
    endfunction

    // follow failure links until a state owns a child for c, root, or the hop bound
    function automatic logic [9:0] fail_walk(logic [9:0] s, logic [7:0] c);
        int hops = 0;
        while (s != 0 && child(s, c) == 0 && hops < NSTATES) begin
            s = fail_ptr[s];
            hops++;
        end
        return s;
    endfunction

    // breadth-first fill of failure links
    task automatic build_links();
        int head = 0;
        int tail = 0;
        logic [9:0] u;
        logic [9:0] v;
        fail_ptr[0] = 0;
        for (int c = 0; c < 256; c++) begin
            v = child(10'd0, 8'(c));
            if (v != 0 && tail < NSTATES) begin
                fail_ptr[v] = 0;
                walk_q[tail++] = v;
            end
        end
        while (head < tail) begin
            u = walk_q[head++];
            for (int c = 0; c < 256; c++) begin
                v = child(u, 8'(c));
                if (v != 0) begin
                    fail_ptr[v] = child(fail_walk(fail_ptr[u], 8'(c)), 8'(c));
                    if (tail < NSTATES) walk_q[tail++] = v;
                end
            end
        end
    endtask

    // apply one accepted beat; queue its result if it makes one
    task automatic apply_cmd(cmd_t cm);
        logic [9:0] nxt;
        logic [9:0] s;
        resp_t r;
        case (cm.act)
            ACT_ADD: begin
                if (built) begin
                    r.id = 0; r.st = ST_LATE_ADD; expected.push_back(r);
                    return;
                end
                if (cm.first) begin
                    ins_at = 0;
                    dropping = 1'b0;
                end
                if (!dropping) begin
                    nxt = child(ins_at, cm.dbyte);
                    if (nxt == 0) begin
                        if (nodes_used >= NSTATES) dropping = 1'b1;
                        else begin
                            nxt = nodes_used[9:0];
                            nodes_used++;
                            child_tbl[{ins_at, cm.dbyte}] = nxt;
                        end
                    end
                end
                if (dropping) begin
                    r.id = 0; r.st = ST_FULL; expected.push_back(r);
                    return;
                end
                ins_at = nxt;
                if (cm.last) begin
                    end_tag[ins_at] = cm.tag;
                    tagged_st[ins_at] = 1'b1;
                end
            end
            ACT_COMPILE: begin
                build_links();
                built = 1'b1;
                r.id = 0; r.st = ST_COMPILED; expected.push_back(r);
            end
            ACT_SCAN: begin
                s = fail_walk(scan_at, cm.dbyte);
                nxt = child(s, cm.dbyte);
                scan_at = (nxt != 0) ? nxt : s;
                r.id = tagged_st[scan_at] ? end_tag[scan_at] : miss_id;
                r.st = ST_SCAN;
                expected.push_back(r);
            end
            default: scan_at = 0;
        endcase
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            gap   <= 0;
        end else if (start && busy) begin
            // beat held until accepted
        end else begin
            if (start) apply_cmd(cur);
            if (gap > 0) begin
                gap   <= gap - 1;
                start <= 1'b0;
            end else if (pending.size() > 0) begin
                cur = pending.pop_front();
                action        <= cur.act;
                data_byte     <= cur.dbyte;
                pattern_start <= cur.first;
                pattern_end   <= cur.last;
                pattern_tag   <= cur.tag;
                start         <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 5);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        resp_t e;
        if (rst_n && result_valid) begin
            if (expected.size() == 0) begin
                $display("%0t: unexpected result beat id=%h status=%0d",
                         $realtime, match_id, status);
                errors++;
            end else begin
                e = expected.pop_front();
                if (match_id !== e.id) begin
                    $display("%0t: match_id expected %h actual %h",
                             $realtime, e.id, match_id);
                    errors++;
                end
                if (status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, e.st, status);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic push(action_t a, logic [7:0] b, logic f, logic l, logic [15:0] t);
        cmd_t cm;
        cm.act = a; cm.dbyte = b; cm.first = f; cm.last = l; cm.tag = t;
        pending.push_back(cm);
    endtask

    // random fields on everything but the action
    task automatic push_junk(action_t a);
        push(a, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic push_pattern(string s, logic [15:0] t);
        for (int i = 0; i < s.len(); i++) begin
            push(ACT_ADD, s[i], i == 0, i == s.len() - 1, t);
            pat_bytes.push_back(s[i]);
        end
    endtask

    task automatic push_rand_pattern();
        int n = $urandom_range(1, 8);
        bit narrow = 1'($urandom_range(0, 1));
        bit cont = ($urandom_range(0, 9) == 0);  // extend previous pattern
        logic [7:0] b;
        logic [15:0] t = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            b = narrow ? 8'(8'h61 + $urandom_range(0, 3)) : 8'($urandom);
            push(ACT_ADD, b, (i == 0) && !cont, i == n - 1, t);
            pat_bytes.push_back(b);
        end
    endtask

    // wait until the block is idle and nothing is owed
    task automatic drain();
        while (pending.size() > 0 || start || busy || expected.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_miss_id(logic [15:0] v);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        miss_id = v;
    endtask

    // scan stream: mostly windows of the stored pattern bytes, some noise
    task automatic push_scans(int n);
        int k = 0;
        int pos;
        int len;
        while (k < n) begin
            case ($urandom_range(0, 9))
                0: push_junk(ACT_SCAN);
                1: push_junk(ACT_REWIND);
                2: if ($urandom_range(0, 3) == 0) push_junk(ACT_ADD);
                default: begin
                    len = $urandom_range(2, 12);
                    pos = $urandom_range(0, pat_bytes.size() - len);
                    for (int i = 0; i < len; i++)
                        push(ACT_SCAN, pat_bytes[pos + i], 1'($urandom), 1'($urandom),
                             16'($urandom));
                    k += len - 1;
                end
            endcase
            k++;
        end
    endtask

    // ---------------- sequence ----------------
    initial begin
        for (int i = 0; i < NSTATES * 256; i++) child_tbl[i] = 0;
        for (int i = 0; i < NSTATES; i++) begin
            fail_ptr[i] = 0; end_tag[i] = 0; tagged_st[i] = 0;
        end
        scan_at = 0; ins_at = 0; nodes_used = 1;
        built = 0; dropping = 0; miss_id = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_miss_id(16'hFFFF);   // waits out the clearing sweep too

        // directed: classic overlapping set, byte extremes, tag extremes
        push(ACT_SCAN, "h", 0, 0, 0);            // scan before any pattern
        push_pattern("he", 16'h0001);
        push_pattern("she", 16'hFFFF);
        push_pattern("his", 16'h0000);
        push_pattern("hers", 16'h1234);
        push(ACT_ADD, 8'h00, 1, 1, 16'hABCD);
        push(ACT_ADD, 8'hFF, 1, 1, 16'h5555);
        push(ACT_ADD, "x", 0, 1, 16'h0007);      // no start mark: extends 0xFF
        pat_bytes.push_back(8'h00);
        pat_bytes.push_back(8'hFF);
        pat_bytes.push_back("x");
        push(ACT_SCAN, "s", 0, 0, 0);            // scan on root-only failure links
        push(ACT_SCAN, "h", 1, 1, 16'hFFFF);
        push(ACT_SCAN, "e", 0, 0, 0);
        push(ACT_REWIND, 8'hFF, 1, 1, 16'hFFFF);
        push(ACT_SCAN, "h", 0, 0, 0);
        drain();

        // fill the trie to overflow
        while (nodes_used < NSTATES) begin
            repeat (20) push_rand_pattern();
            drain();
        end
        repeat (4) push_rand_pattern();          // trie full, tails dropped
        push(ACT_ADD, 8'hFE, 0, 1, 16'h0101);    // still dropped without start
        push(ACT_ADD, "h", 1, 0, 16'h0000);      // existing path still walks
        push(ACT_ADD, "e", 0, 1, 16'h4242);      // retags "he"
        set_miss_id(16'h0000);

        push_junk(ACT_COMPILE);
        push_scans(20);
        push_junk(ACT_COMPILE);                  // repeated compile, same links
        push_junk(ACT_ADD);                      // add after compile
        push_scans(30);
        set_miss_id(16'($urandom));
        push_scans(60);
        set_miss_id(16'hFFFF);
        push_scans(40);
        set_miss_id(16'($urandom));
        drain();
        quiet = 1'b1;                            // closing stretch, back to back
        push_scans(30);
        drain();
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("PASS multi_pattern_byte_matcher");
        else
            $display("FAIL multi_pattern_byte_matcher");
        $finish;
    end

    initial begin
        #100ms;
        $display("FAIL multi_pattern_byte_matcher");
        $finish;
    end

endmodule

### filelist.f
src/mpbm_pkg.sv
src/mpbm_ram.sv
src/mpbm_node_ram.sv
src/mpbm_ctrl.sv
src/multi_pattern_byte_matcher.sv
tb/testbench.sv
